// File: rtl/rvx_pkg.sv
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int unsigned DATA_WORDS_DEF = 1024;
  localparam logic [31:0] SP_RESET = 32'(1999 * 4);

  localparam logic [6:0] OP_LOAD   = 7'd3;
  localparam logic [6:0] OP_IMM    = 7'd19;
  localparam logic [6:0] OP_AUIPC  = 7'd23;
  localparam logic [6:0] OP_STORE  = 7'd35;
  localparam logic [6:0] OP_REG    = 7'd51;
  localparam logic [6:0] OP_LUI    = 7'd55;
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_JALR   = 7'd103;
  localparam logic [6:0] OP_JAL    = 7'd111;
  localparam logic [6:0] F7_ALT    = 7'd32;
  localparam logic [6:0] F7_BASE   = 7'd0;

  localparam logic REQ_EXEC    = 1'b0;
  localparam logic REQ_PRELOAD = 1'b1;

  // result of the execute stage for one item
  typedef struct packed {
    logic [31:0] npc;
    logic        wen;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [31:0] addr;
    logic        load;
    logic        store;
    logic        taken;
    logic        bad;
    logic [2:0]  f3;
  } exec_t;

  // one data memory access
  typedef struct packed {
    logic        rd;
    logic        store;
    logic        preload;
    logic [31:0] addr;
    logic [2:0]  f3;
    logic [31:0] data;
    logic [9:0]  pidx;
  } dmem_req_t;

  function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
    return (idx == 5'd2) ? SP_RESET : 32'd0;
  endfunction

endpackage

// File: rtl/rvx_req_if.sv
`timescale 1ns / 1ps
interface rvx_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] instr_word;
  logic [9:0]  preload_index;
  logic [31:0] preload_data;

  modport source (output valid, req_type, instr_word, preload_index, preload_data,
                  input ready);
  modport sink (input valid, req_type, instr_word, preload_index, preload_data,
                output ready);
endinterface

// File: rtl/rvx_res_if.sv
`timescale 1ns / 1ps
interface rvx_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        wb_enable;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  logic [31:0] mem_address;
  logic        store_done;
  logic        branch_taken;
  logic        illegal;

  modport source (output valid, next_pc, wb_enable, wb_reg, wb_value, mem_address,
                  store_done, branch_taken, illegal, input ready);
  modport sink (input valid, next_pc, wb_enable, wb_reg, wb_value, mem_address,
                store_done, branch_taken, illegal, output ready);
endinterface

// File: rtl/rvx_regfile.sv
`timescale 1ns / 1ps
module rvx_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  ra1,
  input  logic [4:0]  ra2,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] q1,
  output logic [31:0] q2
);
  import rvx_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // write-through on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && wa == ra1) q1 <= wd;
      else if (valid[ra1]) q1 <= mem[ra1];
      else q1 <= rf_reset_value(ra1);
      if (we && wa == ra2) q2 <= wd;
      else if (valid[ra2]) q2 <= mem[ra2];
      else q2 <= rf_reset_value(ra2);
    end
  end

endmodule

// File: rtl/rvx_dmem.sv
`timescale 1ns / 1ps
module rvx_dmem #(
  parameter int unsigned DATA_WORDS = rvx_pkg::DATA_WORDS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  rvx_pkg::dmem_req_t req,
  output logic [31:0]        ld_value
);
  import rvx_pkg::*;

  // DATA_WORDS must be a power of two: word indices wrap by truncation
  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [7:0] q [4];
  logic [1:0] lo_q;
  logic [2:0] f3_q;

  for (genvar L = 0; L < 4; L++) begin : g_lane
    logic [7:0]    mem [DATA_WORDS];
    logic [1:0]    k;
    logic          carry;
    logic [AW-1:0] idx;
    logic [AW-1:0] widx;
    logic [7:0]    wbyte;
    logic          we;
    logic [2:0]    nbytes;

    always_comb begin
      k      = 2'(L) - req.addr[1:0];
      carry  = 2'(L) < req.addr[1:0];
      idx    = req.addr[AW+1:2] + AW'(carry);
      nbytes = 3'd1 << req.f3[1:0];
      if (req.preload) begin
        widx  = AW'(req.pidx);
        wbyte = req.data[8*L +: 8];
        we    = 1'b1;
      end else begin
        widx  = idx;
        wbyte = 8'(req.data >> {k, 3'b000});
        we    = req.store && ({1'b0, k} < nbytes);
      end
    end

    always_ff @(posedge clk) begin
      if (en && we) begin
        mem[widx] <= wbyte;
      end
      if (en && req.rd) begin
        q[L] <= mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && req.rd) begin
      lo_q <= req.addr[1:0];
      f3_q <= req.f3;
    end
  end

  always_comb begin
    logic [31:0] raw;
    raw = '0;
    for (int i = 0; i < 4; i++) begin
      raw[8*i +: 8] = q[2'(lo_q + 2'(i))];
    end
    case (f3_q[1:0])
      2'd0:    ld_value = f3_q[2] ? {24'd0, raw[7:0]} : {{24{raw[7]}}, raw[7:0]};
      2'd1:    ld_value = f3_q[2] ? {16'd0, raw[15:0]} : {{16{raw[15]}}, raw[15:0]};
      default: ld_value = raw;
    endcase
  end

endmodule

// File: rtl/rvx_exec.sv
`timescale 1ns / 1ps
module rvx_exec (
  input  logic [31:0]    instr,
  input  logic [31:0]    pc,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  output rvx_pkg::exec_t ex
);
  import rvx_pkg::*;

  logic [6:0]  op;
  logic [6:0]  f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] alu_b;
  logic [31:0] alu_y;
  logic        alt;
  logic        wr;
  logic        lt;
  logic        ltu;
  logic        eq;

  assign op    = instr[6:0];
  assign f7    = instr[31:25];
  assign f3    = instr[14:12];
  assign rd    = instr[11:7];
  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign alu_b = (op == OP_REG) ? b : imm_i;
  assign alt   = (f7 == F7_ALT) && (op == OP_REG || f3 == 3'd5);
  assign eq    = a == b;
  assign lt    = $signed(a) < $signed(b);
  assign ltu   = a < b;

  always_comb begin
    case (f3)
      3'd0:    alu_y = alt ? a - alu_b : a + alu_b;
      3'd1:    alu_y = a << alu_b[4:0];
      3'd2:    alu_y = {31'd0, $signed(a) < $signed(alu_b)};
      3'd3:    alu_y = {31'd0, a < alu_b};
      3'd4:    alu_y = a ^ alu_b;
      3'd5:    alu_y = alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
      3'd6:    alu_y = a | alu_b;
      default: alu_y = a & alu_b;
    endcase
  end

  always_comb begin
    ex       = '0;
    ex.npc   = pc + 32'd4;
    ex.f3    = f3;
    ex.val   = '0;
    wr       = 1'b0;
    case (op)
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) ex.bad = 1'b1;
        ex.addr = a + imm_i;
        ex.load = 1'b1;
        wr      = 1'b1;
      end
      OP_IMM: begin
        if ((f3 == 3'd1 && f7 != F7_BASE) ||
            (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT)) ex.bad = 1'b1;
        ex.val = alu_y;
        wr     = 1'b1;
      end
      OP_AUIPC: begin
        ex.val = pc + {instr[31:12], 12'd0};
        wr     = 1'b1;
      end
      OP_LUI: begin
        ex.val = {instr[31:12], 12'd0};
        wr     = 1'b1;
      end
      OP_STORE: begin
        if (f3 > 3'd2) ex.bad = 1'b1;
        ex.addr  = a + imm_s;
        ex.store = 1'b1;
      end
      OP_REG: begin
        if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))) ex.bad = 1'b1;
        ex.val = alu_y;
        wr     = 1'b1;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0:    ex.taken = eq;
          3'd1:    ex.taken = !eq;
          3'd4:    ex.taken = lt;
          3'd5:    ex.taken = !lt;
          3'd6:    ex.taken = ltu;
          3'd7:    ex.taken = !ltu;
          default: ex.bad = 1'b1;
        endcase
        if (ex.taken) ex.npc = pc + imm_b;
      end
      OP_JALR: begin
        if (f3 != 3'd0) ex.bad = 1'b1;
        ex.npc   = (a + imm_i) & ~32'd1;
        ex.val   = pc + 32'd4;
        ex.taken = 1'b1;
        wr       = 1'b1;
      end
      OP_JAL: begin
        ex.npc   = pc + imm_j;
        ex.val   = pc + 32'd4;
        ex.taken = 1'b1;
        wr       = 1'b1;
      end
      default: ex.bad = 1'b1;
    endcase
    if (ex.bad) begin
      ex.npc   = pc;
      ex.val   = '0;
      ex.addr  = '0;
      ex.load  = 1'b0;
      ex.store = 1'b0;
      ex.taken = 1'b0;
      wr       = 1'b0;
    end
    ex.wen = wr && rd != 5'd0;
    ex.rd  = ex.wen ? rd : 5'd0;
    if (!ex.wen) ex.val = '0;
  end

endmodule

// File: rtl/rv32i_instruction_executor.sv
`timescale 1ns / 1ps
// RV32I core, one instruction or preload beat per clock. A beat is taken into
// a stage that holds the register file operands, executes there and writes
// data memory, PC and load address; the next stage returns the load bytes and
// holds the result beat, writing the register file as it leaves. A new beat is
// taken in every cycle while results drain. Results are forwarded from the
// result stage, so dependent instructions and loads run back to back. Data
// memory is four byte lanes of DATA_WORDS entries, which must be a power of
// two; a load of a byte never written returns an undefined value. x2 resets
// to 7996, the PC to 0.
module rv32i_instruction_executor #(
  parameter int unsigned DATA_WORDS = rvx_pkg::DATA_WORDS_DEF
) (
  input logic  clk,
  input logic  rst,
  rvx_req_if.sink   req,
  rvx_res_if.source res
);
  import rvx_pkg::*;

  logic        s1_valid;
  logic        s1_type;
  logic [31:0] s1_instr;
  logic [9:0]  s1_pidx;
  logic [31:0] s1_pdata;
  logic        s2_valid;
  exec_t       s2;
  logic [31:0] pc;

  logic        s1_en;
  logic        s2_en;
  logic        s1_move;
  logic        take;
  logic [31:0] q1;
  logic [31:0] q2;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] ld_value;
  logic [31:0] wb_value;
  logic        rf_we;
  exec_t       ex;
  exec_t       s1_res;
  dmem_req_t   mreq;

  assign s2_en   = !s2_valid || res.ready;
  assign s1_en   = !s1_valid || s2_en;
  assign req.ready = s1_en;
  assign take    = req.valid && s1_en;
  assign s1_move = s1_valid && s2_en;

  assign wb_value = s2.load ? ld_value : s2.val;
  assign rf_we    = s2_valid && s2_en && s2.wen;

  rvx_regfile u_rf (
    .clk   (clk),
    .rst   (rst),
    .rd_en (take),
    .ra1   (req.instr_word[19:15]),
    .ra2   (req.instr_word[24:20]),
    .we    (rf_we),
    .wa    (s2.rd),
    .wd    (wb_value),
    .q1    (q1),
    .q2    (q2)
  );

  // forward the beat in the result stage
  always_comb begin
    op_a = q1;
    op_b = q2;
    if (s2_valid && s2.wen && s2.rd == s1_instr[19:15]) op_a = wb_value;
    if (s2_valid && s2.wen && s2.rd == s1_instr[24:20]) op_b = wb_value;
  end

  rvx_exec u_exec (
    .instr (s1_instr),
    .pc    (pc),
    .a     (op_a),
    .b     (op_b),
    .ex    (ex)
  );

  always_comb begin
    s1_res = ex;
    if (s1_type == REQ_PRELOAD) begin
      s1_res     = '0;
      s1_res.npc = pc;
    end
    mreq.rd      = s1_type == REQ_EXEC && ex.load;
    mreq.store   = s1_type == REQ_EXEC && ex.store;
    mreq.preload = s1_type == REQ_PRELOAD;
    mreq.addr    = ex.addr;
    mreq.f3      = ex.f3;
    mreq.data    = (s1_type == REQ_PRELOAD) ? s1_pdata : op_b;
    mreq.pidx    = s1_pidx;
  end

  rvx_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
    .clk      (clk),
    .en       (s1_move),
    .req      (mreq),
    .ld_value (ld_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pc       <= '0;
    end else begin
      if (s1_en) s1_valid <= req.valid;
      if (s2_en) s2_valid <= s1_valid;
      if (s1_move) pc <= s1_res.npc;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_type  <= req.req_type;
      s1_instr <= req.instr_word;
      s1_pidx  <= req.preload_index;
      s1_pdata <= req.preload_data;
    end
    if (s1_move) s2 <= s1_res;
  end

  assign res.valid        = s2_valid;
  assign res.next_pc      = s2.npc;
  assign res.wb_enable    = s2.wen;
  assign res.wb_reg       = s2.rd;
  assign res.wb_value     = s2.wen ? wb_value : 32'd0;
  assign res.mem_address  = s2.addr;
  assign res.store_done   = s2.store;
  assign res.branch_taken = s2.taken;
  assign res.illegal      = s2.bad;

  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.illegal |-> !res.wb_enable && !res.store_done && !res.branch_taken)
    else $error("illegal beat carries side effects");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> s2.rd != 5'd0)
    else $error("write to x0");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_en |=> s1_valid && $stable(s1_instr))
    else $error("execute stage lost a stalled beat");

  a_pc_on_move: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(pc))
    else $error("pc changed without a beat");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rvx_pkg::*;

  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
  localparam logic [31:0] W_FENCE = 32'h0000000F;
  localparam logic [31:0] W_ECALL = 32'h00000073;
  localparam int MEM_BYTES = DATA_WORDS_DEF * 4;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wb_enable;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [31:0] mem_address;
    logic        store_done;
    logic        branch_taken;
    logic        illegal;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  bit   idle_en = 1'b1;
  int   err_cnt = 0;
  int   stall_left = 0;

  logic [31:0] core_regs [32];
  logic [31:0] core_pc;
  logic [7:0]  core_mem [MEM_BYTES];
  bit          core_written [MEM_BYTES];
  outcome_t    pending_outcomes [$];

  rvx_req_if req ();
  rvx_res_if res ();

  rv32i_instruction_executor i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [31:0] alu_calc(logic [2:0] f3, bit alt, logic [31:0] a,
                                           logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // advance the core state by one beat and return what it should report
  task automatic core_execute(input logic ptype, input logic [31:0] ir, input logic [9:0] pidx,
                              input logic [31:0] pdata, output outcome_t o);
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] a, b, npc, val, addr, imm_i, imm_s, imm_b, imm_j;
    bit          wr, st, taken, bad;
    int          n;
    op = ir[6:0]; rd = ir[11:7]; f3 = ir[14:12]; f7 = ir[31:25];
    a = core_regs[ir[19:15]];
    b = core_regs[ir[24:20]];
    imm_i = {{20{ir[31]}}, ir[31:20]};
    imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    npc = core_pc + 4; val = '0; addr = '0;
    wr = 0; st = 0; taken = 0; bad = 0;
    o = '0;
    o.next_pc = core_pc;
    if (ptype == REQ_PRELOAD) begin
      for (int k = 0; k < 4; k++) begin
        core_mem[{pidx, 2'(k)}] = pdata[8*k +: 8];
        core_written[{pidx, 2'(k)}] = 1'b1;
      end
      return;
    end
    case (op)
      OP_LOAD: begin
        if (f3 == F3_SLTU || f3 > F3_LHU) bad = 1;
        else begin
          addr = a + imm_i;
          n = 1 << f3[1:0];
          for (int k = 0; k < n; k++) val[8*k +: 8] = core_mem[12'(addr + k)];
          if (f3 == F3_LB) val = {{24{val[7]}}, val[7:0]};
          if (f3 == F3_LH) val = {{16{val[15]}}, val[15:0]};
          wr = 1;
        end
      end
      OP_IMM: begin
        if ((f3 == F3_SLL && f7 != F7_BASE) ||
            (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) bad = 1;
        else begin
          val = alu_calc(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
          wr = 1;
        end
      end
      OP_AUIPC: begin val = core_pc + {ir[31:12], 12'd0}; wr = 1; end
      OP_LUI:   begin val = {ir[31:12], 12'd0}; wr = 1; end
      OP_STORE: begin
        if (f3 > F3_SW) bad = 1;
        else begin
          addr = a + imm_s;
          n = 1 << f3;
          for (int k = 0; k < n; k++) begin
            core_mem[12'(addr + k)] = b[8*k +: 8];
            core_written[12'(addr + k)] = 1'b1;
          end
          st = 1;
        end
      end
      OP_REG: begin
        if (!(f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))) bad = 1;
        else begin
          val = alu_calc(f3, f7 == F7_ALT, a, b);
          wr = 1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = a == b;
          F3_BNE:  taken = a != b;
          F3_BLT:  taken = $signed(a) < $signed(b);
          F3_BGE:  taken = $signed(a) >= $signed(b);
          F3_BLTU: taken = a < b;
          F3_BGEU: taken = a >= b;
          default: bad = 1;
        endcase
        if (taken) npc = core_pc + imm_b;
      end
      OP_JALR: begin
        if (f3 != F3_ADD) bad = 1;
        else begin
          npc = (a + imm_i) & ~32'd1;
          val = core_pc + 4; wr = 1; taken = 1;
        end
      end
      OP_JAL: begin
        npc = core_pc + imm_j;
        val = core_pc + 4; wr = 1; taken = 1;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      o.illegal = 1'b1;
      return;
    end
    if (wr && rd != 0) begin
      core_regs[rd] = val;
      o.wb_enable = 1'b1;
      o.wb_reg = rd;
      o.wb_value = val;
    end
    core_pc = npc;
    o.next_pc = npc;
    o.mem_address = (op == OP_LOAD || op == OP_STORE) ? addr : '0;
    o.store_done = st;
    o.branch_taken = taken;
  endtask

  // true when a load would read only bytes already written, or would be refused as illegal
  function automatic bit load_ready(input logic [31:0] ir);
    logic [31:0] addr;
    int          n;
    if (ir[14:12] == F3_SLTU || ir[14:12] > F3_LHU) return 1'b1;
    addr = core_regs[ir[19:15]] + {{20{ir[31]}}, ir[31:20]};
    n = 1 << ir[13:12];
    for (int k = 0; k < n; k++) begin
      if (!core_written[12'(addr + k)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input logic ptype, input logic [31:0] ir, input logic [9:0] pidx,
                           input logic [31:0] pdata);
    outcome_t o;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= ptype;
    req.instr_word <= ir;
    req.preload_index <= pidx;
    req.preload_data <= pdata;
    do @(posedge clk); while (!req.ready);
    core_execute(ptype, ir, pidx, pdata, o);
    pending_outcomes.push_back(o);
  endtask

  task automatic exec_instr(input logic [31:0] ir);
    send_beat(REQ_EXEC, ir, 10'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // sink side: random back-pressure bursts
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      res.ready <= 1'b0;
      stall_left <= $urandom_range(1, 19);
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = pending_outcomes.pop_front();
        if (res.next_pc !== e.next_pc) begin
          $error("next_pc: expected %h, got %h", e.next_pc, res.next_pc); err_cnt++;
        end
        if (res.wb_enable !== e.wb_enable) begin
          $error("wb_enable: expected %b, got %b", e.wb_enable, res.wb_enable); err_cnt++;
        end
        if (res.wb_reg !== e.wb_reg) begin
          $error("wb_reg: expected %0d, got %0d", e.wb_reg, res.wb_reg); err_cnt++;
        end
        if (res.wb_value !== e.wb_value) begin
          $error("wb_value: expected %h, got %h", e.wb_value, res.wb_value); err_cnt++;
        end
        if (res.mem_address !== e.mem_address) begin
          $error("mem_address: expected %h, got %h", e.mem_address, res.mem_address);
          err_cnt++;
        end
        if (res.store_done !== e.store_done) begin
          $error("store_done: expected %b, got %b", e.store_done, res.store_done); err_cnt++;
        end
        if (res.branch_taken !== e.branch_taken) begin
          $error("branch_taken: expected %b, got %b", e.branch_taken, res.branch_taken);
          err_cnt++;
        end
        if (res.illegal !== e.illegal) begin
          $error("illegal: expected %b, got %b", e.illegal, res.illegal); err_cnt++;
        end
      end
    end
  end

  function automatic logic [31:0] random_instr();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom); f3 = 3'($urandom);
    case ($urandom_range(0, 11))
      0: begin
        f3 = 3'($urandom_range(0, 4));
        if (f3 == F3_SLTU) f3 = F3_LHU;
        return enc_i(12'($urandom), rs1, f3, rd, OP_LOAD);
      end
      1, 2: begin
        if (f3 == F3_SLL) return enc_r(F7_BASE, 5'($urandom), rs1, f3, rd, OP_IMM);
        if (f3 == F3_SR)
          return enc_r($urandom_range(0, 1) ? F7_ALT : F7_BASE, 5'($urandom), rs1, f3, rd,
                       OP_IMM);
        return enc_i(12'($urandom), rs1, f3, rd, OP_IMM);
      end
      3: return {20'($urandom), rd, $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
      4: return enc_s(12'($urandom), rs2, rs1, 3'($urandom_range(0, 2)));
      5, 6: begin
        f7 = ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1)) ? F7_ALT : F7_BASE;
        return enc_r(f7, rs2, rs1, f3, rd, OP_REG);
      end
      7: begin
        if (f3 == 3'd2 || f3 == 3'd3) f3 = F3_BEQ;
        return enc_b(13'($urandom), rs2, rs1, f3);
      end
      8: return enc_i(12'($urandom), rs1, F3_ADD, rd, OP_JALR);
      9: return enc_j(21'($urandom), rd);
      10: return $urandom;
      default: begin
        // near-miss encodings that must be refused
        case ($urandom_range(0, 4))
          0: return enc_r(7'($urandom_range(1, 127)), rs2, rs1, F3_SLL, rd, OP_IMM);
          1: return enc_r(7'($urandom_range(33, 127)), rs2, rs1, f3, rd, OP_REG);
          2: return enc_s(12'($urandom), rs2, rs1, 3'($urandom_range(3, 7)));
          3: return enc_i(12'($urandom), rs1, 3'($urandom_range(1, 7)), rd, OP_JALR);
          default: return enc_b(13'($urandom), rs2, rs1, 3'($urandom_range(2, 3)));
        endcase
      end
    endcase
  endfunction

  // preload a handful of words; other loads of unwritten bytes are preceded by a store to them
  task automatic test_memory_fill();
    for (int w = 0; w < 32; w++) send_beat(REQ_PRELOAD, $urandom, 10'($urandom), $urandom);
  endtask

  task automatic test_directed();
    exec_instr({20'h80000, 5'd1, OP_LUI});
    exec_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd3, OP_IMM));
    exec_instr(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OP_IMM));
    exec_instr(enc_r(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd5, OP_IMM));
    exec_instr(enc_r(F7_BASE, 5'd31, 5'd1, F3_SR, 5'd6, OP_IMM));
    exec_instr(enc_r(F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd7, OP_IMM));
    exec_instr(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd9, OP_REG));
    exec_instr(enc_r(F7_BASE, 5'd4, 5'd1, F3_SLT, 5'd10, OP_REG));
    exec_instr(enc_r(F7_BASE, 5'd4, 5'd1, F3_SLTU, 5'd11, OP_REG));
    exec_instr(enc_r(F7_ALT, 5'd4, 5'd1, F3_SR, 5'd12, OP_REG));
    exec_instr({20'hFFFFF, 5'd13, OP_AUIPC});
    exec_instr(enc_s(12'h7FF, 5'd3, 5'd2, F3_SW));
    exec_instr(enc_s(12'h800, 5'd1, 5'd2, F3_SH));
    exec_instr(enc_s(12'h001, 5'd4, 5'd0, F3_SB));
    exec_instr(enc_i(12'h7FF, 5'd2, F3_LW, 5'd14, OP_LOAD));
    exec_instr(enc_i(12'h7FF, 5'd2, F3_LB, 5'd15, OP_LOAD));
    exec_instr(enc_i(12'h800, 5'd2, F3_LH, 5'd16, OP_LOAD));
    exec_instr(enc_i(12'h800, 5'd2, F3_LHU, 5'd17, OP_LOAD));
    exec_instr(enc_i(12'h001, 5'd0, F3_LBU, 5'd18, OP_LOAD));
    exec_instr(enc_b(13'h1000, 5'd4, 5'd1, F3_BLT));
    exec_instr(enc_b(13'h0FFE, 5'd0, 5'd0, F3_BNE));
    exec_instr(enc_b(13'h0008, 5'd3, 5'd1, F3_BGEU));
    exec_instr(enc_j(21'h0FFFFE, 5'd0));
    exec_instr(enc_i(12'hFFF, 5'd3, F3_ADD, 5'd19, OP_JALR));
    exec_instr(W_FENCE);
    exec_instr(W_ECALL);
    exec_instr(enc_i(12'h000, 5'd1, F3_SLL, 5'd1, OP_JALR));
    send_beat(REQ_PRELOAD, '0, 10'h3FF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(input int count);
    logic [31:0] ir;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(REQ_PRELOAD, $urandom, 10'($urandom), $urandom);
      end else begin
        ir = random_instr();
        // write the bytes first so the load never reads unwritten memory
        if (ir[6:0] == OP_LOAD && !load_ready(ir))
          exec_instr(enc_s(ir[31:20], 5'($urandom), ir[19:15], {1'b0, ir[13:12]}));
        exec_instr(ir);
      end
    end
  endtask

  // hold the sender until the pipeline is empty, then resume
  task automatic test_drain_pause();
    wait_drained();
    test_random(20);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = REQ_EXEC;
    req.instr_word = '0;
    req.preload_index = '0;
    req.preload_data = '0;
    res.ready = 1'b0;
    foreach (core_regs[i]) core_regs[i] = (i == 2) ? SP_RESET : 32'd0;
    foreach (core_mem[i]) core_mem[i] = '0;
    foreach (core_written[i]) core_written[i] = 1'b0;
    core_pc = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_memory_fill();
    test_directed();
    test_random(350);
    test_drain_pause();
    test_random(200);
    idle_en = 1'b0;
    test_random(120);
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
